[design/fbca_pkg.sv]
// shared constants for the file block chain allocator
`default_nettype none
package fbca_pkg;
	localparam int NUM_ENTRIES_DEF     = 64;
	localparam int RESERVED_BLOCKS_DEF = 1;

	localparam int CMD_W    = 2;
	localparam int ID_W     = 16;
	localparam int STATUS_W = 3;
	localparam int IDXO_W   = 6;
	localparam int CNTO_W   = 7;
	localparam int LIMIT_W  = 11;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd128;

	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EXTEND = 2'd2;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_ENTRY  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd5;
endpackage
`default_nettype wire

[design/file_block_chain_allocator_unit.sv]
// top level: linked-block file allocation table with memory-held state
//
// The block takes one file command per transaction on the s_ side and returns one
// result transaction on the m_ side. After reset a clearing pass formats the table;
// s_tready stays low until it is done (cfg writes are taken at any time). All state
// sits in three one-port-read memories: the entry table (owner, data block, next
// link), a free-block bitmap and a scratch "linked" bitmap. Each command runs a mark
// pass that flags every entry that a same-file entry points to, a find pass that
// finds the chain head, the first free entries and the first free block, then, if a
// head is found, a chain walk that follows the next links through the entry memory,
// then the writes of S_EXEC and, for an extension, S_EXT2, or for a delete another
// pass that clears the file's entries and frees their blocks. The result then waits
// in S_RESP for the output register to be free. A finished result waits in the output
// register while the next command is already accepted.
`default_nettype none
module file_block_chain_allocator_unit
	import fbca_pkg::*;
#(
	parameter int NUM_ENTRIES     = NUM_ENTRIES_DEF,
	parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,   // cmd[1:0], file_id[17:2], zero fill
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,   // status[2:0], entry_index[8:3],
	                                            // block_number[14:9], block_count[21:15]
	input  wire logic                cfg_we,
	input  wire logic [LIMIT_W-1:0]  cfg_wdata  // largest chain length in blocks that may still be extended
);
	localparam int IDX_W = $clog2(NUM_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int ENT_W = ID_W + 2 * IDX_W;
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NUM_ENTRIES);

	// sequencer codes
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MARK  = 4'd2;
	localparam logic [3:0] S_FIND  = 4'd3;
	localparam logic [3:0] S_WALK  = 4'd4;
	localparam logic [3:0] S_WALKD = 4'd5;
	localparam logic [3:0] S_EXEC  = 4'd6;
	localparam logic [3:0] S_EXT2  = 4'd7;
	localparam logic [3:0] S_DEL   = 4'd8;
	localparam logic [3:0] S_RESP  = 4'd9;

	// memories
	logic [ENT_W-1:0] ent_mem [NUM_ENTRIES];
	logic             lnk_mem [NUM_ENTRIES];
	logic             bf_mem  [NUM_ENTRIES];

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             vld_q;      // read data of scan index idx_q is present
	logic [IDX_W-1:0] idx_q;
	logic [LIMIT_W-1:0] limit_q;

	logic [CMD_W-1:0] cmd_q;
	logic [ID_W-1:0]  id_q;

	logic             head_f_q, fe0_f_q, fe1_f_q, fb_f_q;
	logic [IDX_W-1:0] head_q, head_blk_q, fe0_q, fe1_q, fb_q;
	logic [IDX_W-1:0] walk_idx_q, last_q, last_blk_q;
	logic [ID_W-1:0]  last_own_q;
	logic [CNT_W-1:0] walk_cnt_q;

	logic [STATUS_W-1:0] res_st_q;
	logic [IDXO_W-1:0]   res_ent_q, res_blk_q;
	logic [CNTO_W-1:0]   res_cnt_q;

	logic [ENT_W-1:0] ent_rdata_q;
	logic             lnk_rdata_q, bf_rdata_q;

	logic [IDX_W-1:0] ent_raddr;
	logic             ent_we, lnk_we, bf_we;
	logic [IDX_W-1:0] ent_waddr, lnk_waddr, bf_waddr;
	logic [ENT_W-1:0] ent_wdata;
	logic             lnk_wdata, bf_wdata;

	logic             issuing, scan_last, out_free;
	logic [ID_W-1:0]  rd_own;
	logic [IDX_W-1:0] rd_blk, rd_nxt;
	logic             rd_used, rd_match;
	logic [IDX_W-1:0] cnt_idx;

	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign rd_own   = ent_rdata_q[ENT_W-1 -: ID_W];
	assign rd_blk   = ent_rdata_q[2*IDX_W-1 -: IDX_W];
	assign rd_nxt   = ent_rdata_q[IDX_W-1:0];
	assign rd_used  = (rd_blk != '0);
	assign rd_match = rd_used && (rd_own == id_q);

	assign issuing   = ((state_q == S_MARK) || (state_q == S_FIND) || (state_q == S_DEL))
	                   && (cnt_q < N_CNT);
	assign scan_last = (cnt_q == N_CNT) && vld_q;
	assign out_free  = !m_tvalid || m_tready;
	assign s_tready  = (state_q == S_IDLE);

	assign ent_raddr = (state_q == S_WALK) ? walk_idx_q : cnt_idx;

	// memory reads, registered
	always_ff @(posedge clk) begin
		ent_rdata_q <= ent_mem[ent_raddr];
		lnk_rdata_q <= lnk_mem[cnt_idx];
		bf_rdata_q  <= bf_mem[cnt_idx];
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (lnk_we) begin
			lnk_mem[lnk_waddr] <= lnk_wdata;
		end
		if (bf_we) begin
			bf_mem[bf_waddr] <= bf_wdata;
		end
	end

	// write port steering
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = cnt_idx;
		ent_wdata = '0;
		lnk_we    = 1'b0;
		lnk_waddr = cnt_idx;
		lnk_wdata = 1'b0;
		bf_we     = 1'b0;
		bf_waddr  = cnt_idx;
		bf_wdata  = 1'b0;
		case (state_q)
			S_CLR: begin
				// format: every entry free, every block free but the reserved ones
				ent_we   = (cnt_q < N_CNT);
				lnk_we   = (cnt_q < N_CNT);
				bf_we    = (cnt_q < N_CNT);
				bf_wdata = (cnt_q >= CNT_W'(RESERVED_BLOCKS));
			end
			S_MARK: begin
				// flag the entry that a same-file link points at
				lnk_we    = vld_q && rd_match && (rd_nxt != '0);
				lnk_waddr = rd_nxt;
				lnk_wdata = 1'b1;
			end
			S_FIND: begin
				// scratch flags go back to zero behind the scan
				lnk_we    = vld_q;
				lnk_waddr = idx_q;
			end
			S_EXEC: begin
				if (cmd_q == CMD_CREATE && !head_f_q && fe0_f_q && fb_f_q) begin
					ent_we    = 1'b1;
					ent_waddr = fe0_q;
					ent_wdata = {id_q, fb_q, {IDX_W{1'b0}}};
					bf_we     = 1'b1;
					bf_waddr  = fb_q;
				end else if (cmd_q == CMD_EXTEND && head_f_q && fe1_f_q && fb_f_q &&
				             (CMP_W'(walk_cnt_q) <= CMP_W'(limit_q))) begin
					// link the tail to the new entry
					ent_we    = 1'b1;
					ent_waddr = last_q;
					ent_wdata = {last_own_q, last_blk_q, fe1_q};
				end
			end
			S_EXT2: begin
				ent_we    = 1'b1;
				ent_waddr = fe1_q;
				ent_wdata = {id_q, fb_q, {IDX_W{1'b0}}};
				bf_we     = 1'b1;
				bf_waddr  = fb_q;
			end
			S_DEL: begin
				ent_we    = vld_q && rd_match;
				ent_waddr = idx_q;
				bf_we     = vld_q && rd_match;
				bf_waddr  = rd_blk;
				bf_wdata  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// scan pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= issuing;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= cnt_idx;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (cnt_q == N_CNT) begin
						state_q <= S_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_MARK;
						cnt_q   <= '0;
					end
				end
				S_MARK: begin
					if (issuing) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_last) begin
						state_q <= S_FIND;
						cnt_q   <= '0;
					end
				end
				S_FIND: begin
					if (issuing) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_last) begin
						cnt_q <= '0;
						// head is known only after the final element
						if (head_f_q || (rd_match && !lnk_rdata_q)) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_WALK: begin
					state_q <= S_WALKD;
				end
				S_WALKD: begin
					if (rd_nxt != '0 && walk_cnt_q < N_CNT) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == CMD_DELETE && head_f_q) begin
						state_q <= S_DEL;
					end else if (cmd_q == CMD_EXTEND && head_f_q && fe1_f_q && fb_f_q &&
					             (CMP_W'(walk_cnt_q) <= CMP_W'(limit_q))) begin
						state_q <= S_EXT2;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_EXT2: begin
					state_q <= S_RESP;
				end
				S_DEL: begin
					if (issuing) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_last) begin
						state_q <= S_RESP;
						cnt_q   <= '0;
					end
				end
				S_RESP: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-command datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q    <= s_tdata[CMD_W-1:0];
				id_q     <= s_tdata[CMD_W +: ID_W];
				head_f_q <= 1'b0;
				fe0_f_q  <= 1'b0;
				fe1_f_q  <= 1'b0;
				fb_f_q   <= 1'b0;
			end
			S_FIND: begin
				if (vld_q) begin
					if (rd_match && !lnk_rdata_q && !head_f_q) begin
						head_f_q   <= 1'b1;
						head_q     <= idx_q;
						head_blk_q <= rd_blk;
						walk_idx_q <= idx_q;
					end
					if (!rd_used && !fe0_f_q) begin
						fe0_f_q <= 1'b1;
						fe0_q   <= idx_q;
					end
					// an extension never takes entry zero
					if (!rd_used && idx_q != '0 && !fe1_f_q) begin
						fe1_f_q <= 1'b1;
						fe1_q   <= idx_q;
					end
					if (bf_rdata_q && !fb_f_q) begin
						fb_f_q <= 1'b1;
						fb_q   <= idx_q;
					end
				end
				walk_cnt_q <= CNT_W'(1);
				if (scan_last && !head_f_q && !(rd_match && !lnk_rdata_q)) begin
					walk_cnt_q <= '0;
				end
			end
			S_WALKD: begin
				if (rd_nxt != '0 && walk_cnt_q < N_CNT) begin
					walk_idx_q <= rd_nxt;
					walk_cnt_q <= walk_cnt_q + 1'b1;
				end else begin
					last_q     <= walk_idx_q;
					last_own_q <= rd_own;
					last_blk_q <= rd_blk;
				end
			end
			S_EXEC: begin
				res_st_q  <= ST_OK;
				res_ent_q <= '0;
				res_blk_q <= '0;
				res_cnt_q <= CNTO_W'(walk_cnt_q);
				case (cmd_q)
					CMD_CREATE: begin
						if (head_f_q) begin
							res_st_q <= ST_EXISTS;
						end else if (!fe0_f_q) begin
							res_st_q <= ST_NO_ENTRY;
						end else if (!fb_f_q) begin
							res_st_q <= ST_NO_BLOCK;
						end else begin
							res_ent_q <= IDXO_W'(fe0_q);
							res_blk_q <= IDXO_W'(fb_q);
							res_cnt_q <= CNTO_W'(1);
						end
					end
					CMD_DELETE: begin
						if (!head_f_q) begin
							res_st_q <= ST_NOT_FOUND;
						end else begin
							res_cnt_q <= '0;
						end
					end
					CMD_EXTEND: begin
						if (!head_f_q) begin
							res_st_q <= ST_NOT_FOUND;
						end else if (CMP_W'(walk_cnt_q) > CMP_W'(limit_q)) begin
							res_st_q <= ST_TOO_LARGE;
						end else if (!fe1_f_q) begin
							res_st_q <= ST_NO_ENTRY;
						end else if (!fb_f_q) begin
							res_st_q <= ST_NO_BLOCK;
						end else begin
							res_ent_q <= IDXO_W'(fe1_q);
							res_blk_q <= IDXO_W'(fb_q);
							res_cnt_q <= CNTO_W'(walk_cnt_q + 1'b1);
						end
					end
					default: begin
						if (!head_f_q) begin
							res_st_q <= ST_NOT_FOUND;
						end else begin
							res_ent_q <= IDXO_W'(head_q);
							res_blk_q <= IDXO_W'(head_blk_q);
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// output register, loaded as the result transaction is offered
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			m_tdata <= {2'b00, res_cnt_q, res_blk_q, res_ent_q, res_st_q};
		end
	end

	// no command is taken while the table is being formatted
	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !s_tready)
		else $error("command accepted during clearing pass");

	// the new entry of an extension is never the tail it hangs from
	a_ext_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXT2 |-> fe1_q != last_q)
		else $error("extension entry equals chain tail");

	// a block handed out is never one of the reserved blocks
	a_no_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		(bf_we && !bf_wdata && state_q != S_CLR) |-> (bf_waddr >= IDX_W'(RESERVED_BLOCKS)))
		else $error("reserved block allocated");

	// chain walk stays bounded by the table depth
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALKD |-> walk_cnt_q <= N_CNT)
		else $error("chain walk out of bounds");
endmodule
`default_nettype wire
